### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer core.
// Stream layout widths, control codes, command and state types.
// No dependencies; every other file of the core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Default screen geometry.
   localparam int DEF_COLUMNS   = 80;
   localparam int DEF_ROWS      = 25;
   localparam int DEF_TAB_WIDTH = 8;

   // Field widths of the stream payloads.
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ADDR_W   = 11;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int OFFS_W   = 11;
   localparam int CELL_W   = 16;
   localparam int COLOR_W  = 4;
   localparam int ATTR_W   = 2 * COLOR_W;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_PAD_W  = REQ_DATA_W - (CHAR_W + ADDR_W);
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - (COL_W + ROW_W + OFFS_W + CELL_W);

   // Character codes with special meaning.
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // Color register values after reset.
   localparam logic [COLOR_W-1:0] FORE_RESET = 4'hF;
   localparam logic [COLOR_W-1:0] BACK_RESET = 4'h0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_FORE_COLOR = 1'b0,
      CSR_BACK_COLOR = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_PRINT,
      CMD_BACKSPACE,
      CMD_TAB,
      CMD_CR,
      CMD_LF,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [CHAR_W-1:0]       char_code;
      logic [ADDR_W-1:0]       cell_address;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOAD,
      ST_EXEC,
      ST_FILL,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

### rtl/core/tcw_front.sv
// Front end of the text console writer: accepts request transactions and
// classifies them into commands for the back end.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] char_code, [18:8] cell_address, upper bits zero
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] opcode
   input  logic [tcw_pkg::OPCODE_W-1:0]       req_tuser,
   input  tcw_pkg::back_status_type           status,
   input  logic                               q_full,
   output logic                               q_push,
   output tcw_pkg::cmd_type                   q_cmd
);
   import tcw_pkg::*;

   opcode_type        op;
   logic [CHAR_W-1:0] char_code;
   cmd_kind_type      kind;

   assign op        = opcode_type'(req_tuser);
   assign char_code = req_tdata[CHAR_W-1:0];

   always_comb begin
      kind = CMD_NONE;
      unique case (op)
         OP_PUT: begin
            if (char_code >= CH_SPACE) begin
               kind = CMD_PRINT;
            end else begin
               unique case (char_code)
                  CH_BACKSPACE: kind = CMD_BACKSPACE;
                  CH_TAB:       kind = CMD_TAB;
                  CH_CR:        kind = CMD_CR;
                  CH_LF:        kind = CMD_LF;
                  default:      kind = CMD_NONE;
               endcase
            end
         end
         OP_CLEAR: kind = CMD_CLEAR;
         OP_READ:  kind = CMD_READ;
         default:  kind = CMD_NONE;
      endcase
   end

   // Nothing is taken while the screen is being cleared after reset.
   assign req_tready = !q_full && !status.init_busy;
   assign q_push     = req_tvalid && req_tready;

   assign q_cmd.kind         = kind;
   assign q_cmd.char_code    = char_code;
   assign q_cmd.cell_address = req_tdata[CHAR_W +: ADDR_W];

endmodule

`default_nettype wire

### rtl/core/tcw_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on tcw_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcw_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output tcw_pkg::cmd_type  head
);
   import tcw_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/core/tcw_back.sv
// Back end of the text console writer: screen memory, cursor, color
// registers and the sequencer that executes commands and issues results.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
   parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS      = tcw_pkg::DEF_ROWS,
   parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [0:0]                      csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]     csr_data,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  tcw_pkg::cmd_type                q_cmd,
   output tcw_pkg::back_status_type        status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tcw_pkg::*;

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int AW       = $clog2(CELLS);
   localparam int CW       = $clog2(COLUMNS);
   localparam int RW       = $clog2(ROWS);
   localparam int TW       = $clog2(TAB_WIDTH);
   localparam int ColSumW  = CW + 5;
   localparam int RowSumW  = RW + 1;
   localparam int LeftW    = $clog2(CELLS + 1);
   localparam int BaseW    = AW + 1;
   localparam int SumW     = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [TW-1:0]        phase_ff, phase_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [AW-1:0]        lin_ff, lin_in;
   logic [AW-1:0]        fill_addr_ff, fill_addr_in;
   logic [LeftW-1:0]     fill_left_ff, fill_left_in;
   logic [ATTR_W-1:0]    fill_attr_ff, fill_attr_in;
   logic [COLOR_W-1:0]   fore_ff, fore_in;
   logic [COLOR_W-1:0]   back_ff, back_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [CELL_W-1:0]    rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CELL_W-1:0]    screen_mem [CELLS];

   logic [AW-1:0]        cur_lin;
   logic [SumW-1:0]      sel_lin, phys_sum;
   logic [AW-1:0]        phys_addr;
   logic                 addr_in_range;
   logic [BaseW-1:0]     base_sum;
   logic [AW-1:0]        base_next;
   logic [ColSumW-1:0]   col_step;
   logic [RowSumW-1:0]   row_step;
   logic [TW-1:0]        phase_step;
   logic                 need_scroll;
   logic                 fill_last;
   logic                 rsp_free;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic                 rsp_load;

   // Linear cursor position on the logical screen.
   assign cur_lin = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);

   // Logical rows are rotated by base_ff so a scroll only blanks one row.
   assign sel_lin   = (cmd_ff.kind == CMD_READ) ? SumW'(cmd_ff.cell_address)
                                                : SumW'(lin_ff);
   assign phys_sum  = sel_lin + SumW'(base_ff);
   assign phys_addr = (phys_sum >= SumW'(CELLS)) ? AW'(phys_sum - SumW'(CELLS))
                                                 : AW'(phys_sum);
   assign addr_in_range = SumW'(cmd_ff.cell_address) < SumW'(CELLS);

   assign base_sum  = BaseW'(base_ff) + BaseW'(COLUMNS);
   assign base_next = (base_sum >= BaseW'(CELLS)) ? AW'(base_sum - BaseW'(CELLS))
                                                  : AW'(base_sum);

   assign fill_last = (fill_left_ff == LeftW'(1));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // Cursor movement for one character, including line wrap.
   always_comb begin
      col_step   = ColSumW'(col_ff);
      row_step   = RowSumW'(row_ff);
      phase_step = phase_ff;
      unique case (cmd_ff.kind)
         CMD_BACKSPACE: begin
            if (col_ff != '0) begin
               col_step   = ColSumW'(col_ff) - ColSumW'(1);
               phase_step = (phase_ff == '0) ? TW'(TAB_WIDTH - 1) : phase_ff - TW'(1);
            end
         end
         CMD_TAB: begin
            col_step   = ColSumW'(col_ff) + ColSumW'(TAB_WIDTH) - ColSumW'(phase_ff);
            phase_step = '0;
         end
         CMD_CR: begin
            col_step   = '0;
            phase_step = '0;
         end
         CMD_LF: begin
            col_step   = '0;
            row_step   = RowSumW'(row_ff) + RowSumW'(1);
            phase_step = '0;
         end
         CMD_PRINT: begin
            col_step   = ColSumW'(col_ff) + ColSumW'(1);
            phase_step = (phase_ff == TW'(TAB_WIDTH - 1)) ? '0 : phase_ff + TW'(1);
         end
         default: begin
            col_step = ColSumW'(col_ff);
         end
      endcase
      if (col_step >= ColSumW'(COLUMNS)) begin
         col_step   = '0;
         row_step   = row_step + RowSumW'(1);
         phase_step = '0;
      end
      need_scroll = (row_step >= RowSumW'(ROWS));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd_ff.kind == CMD_CLEAR || need_scroll) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            if (fill_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // State machine outputs.
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = fill_addr_ff;
      mem_raddr = phys_addr;
      mem_wdata = {fill_attr_ff, CH_SPACE};
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_FILL: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            q_pop = q_valid;
         end
         ST_EXEC: begin
            if (cmd_ff.kind == CMD_PRINT) begin
               mem_we    = 1'b1;
               mem_waddr = phys_addr;
               mem_wdata = {back_ff, fore_ff, cmd_ff.char_code};
            end
            mem_re = (cmd_ff.kind == CMD_READ);
         end
         ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      base_in      = base_ff;
      lin_in       = lin_ff;
      fill_addr_in = fill_addr_ff;
      fill_left_in = fill_left_ff;
      fill_attr_in = fill_attr_ff;
      fore_in      = fore_ff;
      back_in      = back_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FORE_COLOR: fore_in = csr_data;
            CSR_BACK_COLOR: back_in = csr_data;
            default:        fore_in = fore_ff;
         endcase
      end

      if (q_pop) begin
         cmd_in = q_cmd;
      end
      if (state_ff == ST_LOAD) begin
         lin_in = cur_lin;
      end
      if (state_ff == ST_EXEC) begin
         rd_ok_in     = (cmd_ff.kind == CMD_READ) && addr_in_range;
         fill_attr_in = {back_ff, fore_ff};
         col_in       = CW'(col_step);
         row_in       = need_scroll ? RW'(ROWS - 1) : RW'(row_step);
         phase_in     = phase_step;
         if (need_scroll) begin
            // The old top row becomes the new bottom row.
            fill_addr_in = base_ff;
            fill_left_in = LeftW'(COLUMNS);
            base_in      = base_next;
         end
         if (cmd_ff.kind == CMD_CLEAR) begin
            col_in       = '0;
            row_in       = '0;
            phase_in     = '0;
            base_in      = '0;
            fill_addr_in = '0;
            fill_left_in = LeftW'(CELLS);
         end
      end
      if (state_ff == ST_INIT || state_ff == ST_FILL) begin
         fill_addr_in = fill_addr_ff + AW'(1);
         fill_left_in = fill_left_ff - LeftW'(1);
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}},
                         rd_ok_ff ? rd_data_ff : {CELL_W{1'b0}},
                         OFFS_W'(cur_lin),
                         ROW_W'(row_ff),
                         COL_W'(col_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         base_ff      <= '0;
         fill_addr_ff <= '0;
         fill_left_ff <= LeftW'(CELLS);
         fill_attr_ff <= {BACK_RESET, FORE_RESET};
         fore_ff      <= FORE_RESET;
         back_ff      <= BACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         base_ff      <= base_in;
         fill_addr_ff <= fill_addr_in;
         fill_left_ff <= fill_left_in;
         fill_attr_ff <= fill_attr_in;
         fore_ff      <= fore_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      lin_ff      <= lin_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Screen memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   assign status.init_busy = (state_ff == ST_INIT);
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/text_console_writer_core.sv
// Text console writer core. A character-cell screen (COLUMNS x ROWS cells
// of 16 bits, attribute byte above character byte) with a cursor. Request
// opcodes put a character (backspace, tab, carriage return, line feed,
// printable bytes), clear the screen or read one cell; every request gives
// one response with the cursor column, row and linear offset, plus the cell
// for a read. A front end classifies requests into a two-entry queue and a
// back end executes them, one at a time. An ordinary request passes through
// the back end sequencer states in order (take from the queue, form the
// address, execute, respond); the respond step waits while an earlier
// response is still waiting on rsp_tready. A put that scrolls adds one memory
// write per cell of the new bottom row, since the screen rows rotate through
// a base offset. A clear adds one memory write per cell of the screen. After
// reset the core blanks every cell of the memory and takes no request
// meanwhile; configuration writes are accepted at any time and are always
// ready.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
   parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS      = tcw_pkg::DEF_ROWS,
   parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] char_code, [18:8] cell_address, upper bits zero
   input  logic [tcw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] opcode
   input  logic [tcw_pkg::OPCODE_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_offset,
   // [38:23] cell_data, upper bit zero
   output logic [tcw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [0:0]                       csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]      csr_data
);
   import tcw_pkg::*;

   back_status_type status;
   cmd_type         push_cmd;
   cmd_type         head_cmd;
   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_valid;

   assign csr_ready = 1'b1;

   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   tcw_back #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (head_cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
